/* hw/rtl/ghp_pkg.sv */
// Shared types for the generational handle pool: operation and status codes
// and the sequencer states. Depends on nothing.
package ghp_pkg;

	typedef enum logic [1:0] {
		OP_REGISTER = 2'd0,
		OP_DESTROY  = 2'd1,
		OP_RESOLVE  = 2'd2,
		OP_COLLECT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOKUP,
		S_POPPED,
		S_SWEEP,
		S_DONE
	} state_t;

endpackage

/* hw/rtl/ghp_req_if.sv */
// Request channel of the generational handle pool: valid/ready plus one
// operation beat. Depends on ghp_pkg for the operation code.
interface ghp_req_if #(
	parameter int IDX_W = 10,
	parameter int GEN_W = 16,
	parameter int PAY_W = 32
);
	logic                 valid;
	logic                 ready;
	ghp_pkg::op_t         operation;
	logic [IDX_W-1:0]     slot_index;
	logic [GEN_W-1:0]     handle_generation;
	logic [PAY_W-1:0]     payload;

	modport source (
		output valid, operation, slot_index, handle_generation, payload,
		input  ready
	);
	modport sink (
		input  valid, operation, slot_index, handle_generation, payload,
		output ready
	);
endinterface

/* hw/rtl/ghp_rsp_if.sv */
// Response channel of the generational handle pool: valid/ready plus one
// result beat. Depends on ghp_pkg for the status code.
interface ghp_rsp_if #(
	parameter int IDX_W = 10,
	parameter int GEN_W = 16,
	parameter int PAY_W = 32,
	parameter int CNT_W = 11
);
	logic                 valid;
	logic                 ready;
	ghp_pkg::status_t     status;
	logic [IDX_W-1:0]     result_index;
	logic [GEN_W-1:0]     result_generation;
	logic [PAY_W-1:0]     result_payload;
	logic [CNT_W-1:0]     freed_count;
	logic [CNT_W-1:0]     occupied_count;

	modport source (
		output valid, status, result_index, result_generation, result_payload,
		       freed_count, occupied_count,
		input  ready
	);
	modport sink (
		input  valid, status, result_index, result_generation, result_payload,
		       freed_count, occupied_count,
		output ready
	);
endinterface

/* hw/rtl/generational_handle_pool.sv */
// Generational handle pool: slot table and free stack in two synchronous
// memories, driven by a read-modify-write sequencer.
// Depends on ghp_pkg, ghp_req_if and ghp_rsp_if.
//
// Usage: one request beat on req (operation, slot_index, handle_generation,
// payload) yields exactly one result beat on rsp. Requests are taken one at a
// time; req.ready is high only while the sequencer is idle.
// Steps from request beat to result valid, through the registered reads of the
// slot memory and of the free stack:
//   register from the free stack  stack read, then slot read
//   register of a fresh slot      slot write
//   destroy, resolve              slot read (destroy writes back on a hit)
//   collect                       one slot read a cycle below the high-water mark,
//                                 write-back of a freed previous slot alongside
// The next request is taken in the cycle after the result is loaded.
// The result sits in an output register, so the next request is taken while
// a result still waits on a stalled receiver; a second result then holds in
// the done state until the first beat is taken.
// Reset clears the counters and the control state only. A slot at or above
// the high-water mark is only read by a handle check that discards it, and a
// fresh slot is written whole before use, so the memories need no clearing.
module generational_handle_pool #(
	parameter int SLOTS         = 1024,
	parameter int GEN_WIDTH     = 16,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	ghp_req_if.sink  req,
	ghp_rsp_if.source rsp
);

	localparam int IDX_W    = $clog2(SLOTS);
	localparam int CNT_W    = $clog2(SLOTS + 1);
	localparam int WORD_W   = GEN_WIDTH + 2 + PAYLOAD_WIDTH;
	localparam int PEND_BIT = PAYLOAD_WIDTH;
	localparam int OCC_BIT  = PAYLOAD_WIDTH + 1;

	// sequencer and counters
	ghp_pkg::state_t          state_q, state_d;
	logic [CNT_W-1:0]         free_depth_q, high_water_q, live_q;
	logic                     out_valid_q;

	// captured request
	ghp_pkg::op_t             op_q;
	logic [IDX_W-1:0]         idx_q;
	logic [GEN_WIDTH-1:0]     gen_q;
	logic [PAYLOAD_WIDTH-1:0] pay_q;
	logic [IDX_W-1:0]         slot_q;
	logic                     pop_q;

	// sweep
	logic [CNT_W-1:0]         sweep_q;
	logic [IDX_W-1:0]         sweep_idx_s1;
	logic [CNT_W-1:0]         freed_q;

	// staged and output result
	ghp_pkg::status_t         res_status_q, out_status_q;
	logic [IDX_W-1:0]         res_index_q, out_index_q;
	logic [GEN_WIDTH-1:0]     res_gen_q, out_gen_q;
	logic [PAYLOAD_WIDTH-1:0] res_pay_q, out_pay_q;
	logic [CNT_W-1:0]         out_freed_q, out_occ_q;

	// memories
	logic [WORD_W-1:0]        slot_mem [SLOTS];
	logic [WORD_W-1:0]        slot_rdata_q;
	logic [IDX_W-1:0]         stk_mem [SLOTS];
	logic [IDX_W-1:0]         stk_rdata_q;

	logic                     slot_re, slot_we, stk_re, stk_we;
	logic [IDX_W-1:0]         slot_raddr, slot_waddr, stk_raddr, stk_waddr, stk_wdata;
	logic [WORD_W-1:0]        slot_wdata;

	logic                     accept, out_load, stk_nonempty, pool_full, handle_hit;
	logic                     sweep_free, sweep_more, stk_room;
	logic [CNT_W-1:0]         depth_dec;
	logic [GEN_WIDTH-1:0]     rd_gen;
	logic                     rd_occ, rd_pend;
	logic [PAYLOAD_WIDTH-1:0] rd_pay;

	assign rd_gen  = slot_rdata_q[WORD_W-1 -: GEN_WIDTH];
	assign rd_occ  = slot_rdata_q[OCC_BIT];
	assign rd_pend = slot_rdata_q[PEND_BIT];
	assign rd_pay  = slot_rdata_q[PAYLOAD_WIDTH-1:0];

	assign accept       = req.valid && req.ready;
	assign out_load     = !out_valid_q || rsp.ready;
	assign stk_nonempty = free_depth_q != '0;
	assign stk_room     = free_depth_q != CNT_W'(SLOTS);
	assign pool_full    = high_water_q == CNT_W'(SLOTS);
	assign depth_dec    = free_depth_q - CNT_W'(1);
	assign handle_hit   = (CNT_W'(idx_q) < high_water_q) && (rd_gen == gen_q) && rd_occ;
	assign sweep_free   = rd_pend && rd_occ;
	assign sweep_more   = sweep_q < high_water_q;

	always_comb begin
		state_d    = state_q;
		req.ready  = 1'b0;
		slot_re    = 1'b0;
		slot_raddr = '0;
		slot_we    = 1'b0;
		slot_waddr = '0;
		slot_wdata = '0;
		stk_re     = 1'b0;
		stk_raddr  = '0;
		stk_we     = 1'b0;
		stk_waddr  = '0;
		stk_wdata  = '0;
		case (state_q)
			ghp_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					case (req.operation)
						ghp_pkg::OP_REGISTER: begin
							stk_re    = stk_nonempty;
							stk_raddr = depth_dec[IDX_W-1:0];
							state_d   = ghp_pkg::S_LOOKUP;
						end
						ghp_pkg::OP_DESTROY, ghp_pkg::OP_RESOLVE: begin
							slot_re    = 1'b1;
							slot_raddr = req.slot_index;
							state_d    = ghp_pkg::S_LOOKUP;
						end
						ghp_pkg::OP_COLLECT: begin
							if (high_water_q != '0) begin
								slot_re    = 1'b1;
								slot_raddr = '0;
								state_d    = ghp_pkg::S_SWEEP;
							end else begin
								state_d = ghp_pkg::S_DONE;
							end
						end
						default: state_d = ghp_pkg::S_DONE;
					endcase
				end
			end
			ghp_pkg::S_LOOKUP: begin
				state_d = ghp_pkg::S_DONE;
				case (op_q)
					ghp_pkg::OP_REGISTER: begin
						if (pop_q) begin
							slot_re    = 1'b1;
							slot_raddr = stk_rdata_q;
							state_d    = ghp_pkg::S_POPPED;
						end else if (!pool_full) begin
							// fresh slot: generation starts at zero
							slot_we    = 1'b1;
							slot_waddr = high_water_q[IDX_W-1:0];
							slot_wdata = {{GEN_WIDTH{1'b0}}, 1'b1, 1'b0, pay_q};
						end
					end
					ghp_pkg::OP_DESTROY: begin
						if (handle_hit) begin
							slot_we    = 1'b1;
							slot_waddr = idx_q;
							slot_wdata = {rd_gen, 1'b1, 1'b1, rd_pay};
						end
					end
					default: ;
				endcase
			end
			ghp_pkg::S_POPPED: begin
				slot_we    = 1'b1;
				slot_waddr = slot_q;
				slot_wdata = {rd_gen, 1'b1, 1'b0, pay_q};
				state_d    = ghp_pkg::S_DONE;
			end
			ghp_pkg::S_SWEEP: begin
				// write back the slot read last cycle if it is freed, read the next one while any remain
				if (sweep_free) begin
					slot_we    = 1'b1;
					slot_waddr = sweep_idx_s1;
					slot_wdata = {rd_gen + GEN_WIDTH'(1), 1'b0, 1'b0, rd_pay};
					stk_we     = stk_room;
					stk_waddr  = free_depth_q[IDX_W-1:0];
					stk_wdata  = sweep_idx_s1;
				end
				if (sweep_more) begin
					slot_re    = 1'b1;
					slot_raddr = sweep_q[IDX_W-1:0];
				end else begin
					state_d = ghp_pkg::S_DONE;
				end
			end
			ghp_pkg::S_DONE: begin
				if (out_load) begin
					state_d = ghp_pkg::S_IDLE;
				end
			end
			default: state_d = ghp_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ghp_pkg::S_IDLE;
			free_depth_q <= '0;
			high_water_q <= '0;
			live_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && req.operation == ghp_pkg::OP_REGISTER && stk_nonempty) begin
				free_depth_q <= depth_dec;
			end
			if (state_q == ghp_pkg::S_LOOKUP && op_q == ghp_pkg::OP_REGISTER
			    && !pop_q && !pool_full) begin
				high_water_q <= high_water_q + CNT_W'(1);
				live_q       <= live_q + CNT_W'(1);
			end
			if (state_q == ghp_pkg::S_POPPED && !rd_occ) begin
				live_q <= live_q + CNT_W'(1);
			end
			if (state_q == ghp_pkg::S_SWEEP && sweep_free) begin
				if (stk_room) begin
					free_depth_q <= free_depth_q + CNT_W'(1);
				end
				if (live_q != '0) begin
					live_q <= live_q - CNT_W'(1);
				end
			end
			if (state_q == ghp_pkg::S_DONE && out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= req.operation;
			idx_q        <= req.slot_index;
			gen_q        <= req.handle_generation;
			pay_q        <= req.payload;
			pop_q        <= stk_nonempty;
			freed_q      <= '0;
			sweep_q      <= CNT_W'(1);
			sweep_idx_s1 <= '0;
			res_status_q <= ghp_pkg::ST_OK;
			res_index_q  <= req.slot_index;
			res_gen_q    <= '0;
			res_pay_q    <= '0;
		end
		case (state_q)
			ghp_pkg::S_LOOKUP: begin
				slot_q <= stk_rdata_q;
				case (op_q)
					ghp_pkg::OP_REGISTER: begin
						if (!pop_q) begin
							if (pool_full) begin
								res_status_q <= ghp_pkg::ST_FULL;
								res_index_q  <= '0;
							end else begin
								res_index_q <= high_water_q[IDX_W-1:0];
							end
						end
					end
					ghp_pkg::OP_DESTROY: begin
						if (!handle_hit) begin
							res_status_q <= ghp_pkg::ST_INVALID;
						end
					end
					ghp_pkg::OP_RESOLVE: begin
						if (handle_hit) begin
							res_pay_q <= rd_pay;
						end else begin
							res_status_q <= ghp_pkg::ST_INVALID;
						end
					end
					default: ;
				endcase
			end
			ghp_pkg::S_POPPED: begin
				res_index_q <= slot_q;
				res_gen_q   <= rd_gen;
			end
			ghp_pkg::S_SWEEP: begin
				if (sweep_free) begin
					freed_q <= freed_q + CNT_W'(1);
				end
				if (sweep_more) begin
					sweep_idx_s1 <= sweep_q[IDX_W-1:0];
					sweep_q      <= sweep_q + CNT_W'(1);
				end
			end
			ghp_pkg::S_DONE: begin
				if (out_load) begin
					out_status_q <= res_status_q;
					out_index_q  <= res_index_q;
					out_gen_q    <= res_gen_q;
					out_pay_q    <= res_pay_q;
					out_freed_q  <= freed_q;
					out_occ_q    <= live_q;
				end
			end
			default: ;
		endcase
	end

	// slot table: generation, occupied, pending, payload
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		if (slot_re) begin
			slot_rdata_q <= slot_mem[slot_raddr];
		end
	end

	// free stack of released indices
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		if (stk_re) begin
			stk_rdata_q <= stk_mem[stk_raddr];
		end
	end

	assign rsp.valid             = out_valid_q;
	assign rsp.status            = out_status_q;
	assign rsp.result_index      = out_index_q;
	assign rsp.result_generation = out_gen_q;
	assign rsp.result_payload    = out_pay_q;
	assign rsp.freed_count       = out_freed_q;
	assign rsp.occupied_count    = out_occ_q;

	// every slot below the mark is either live or on the free stack
	a_bookkeeping: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ghp_pkg::S_IDLE |->
			({1'b0, free_depth_q} + {1'b0, live_q}) == {1'b0, high_water_q})
		else $error("free stack and live count do not cover the high-water mark");

	a_mark_bound: assert property (@(posedge clk) disable iff (!arst_n)
		high_water_q <= CNT_W'(SLOTS))
		else $error("high-water mark beyond capacity");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		slot_we && slot_re |-> slot_waddr != slot_raddr)
		else $error("slot read and write hit the same entry in one cycle");

	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ghp_pkg::S_SWEEP |-> CNT_W'(sweep_idx_s1) < high_water_q)
		else $error("sweep beyond the high-water mark");

	a_done_then_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ghp_pkg::S_DONE && out_load |=> out_valid_q)
		else $error("result beat not presented after completion");

endmodule

/* sim/ghp_pool_checker.sv */
// Checker for the generational handle pool: keeps its own slot table and free
// stack, predicts every result beat and compares it with what the pool returns.
// Depends on ghp_pkg, ghp_req_if and ghp_rsp_if.
module ghp_pool_checker #(
	parameter int SLOTS = 1024
) (
	input  logic clk,
	input  logic arst_n,
	ghp_req_if   req,
	ghp_rsp_if   rsp,
	output int   fail_count,
	output int   pending_count
);

	typedef struct packed {
		ghp_pkg::status_t status;
		logic [9:0]       index;
		logic [15:0]      generation;
		logic [31:0]      payload;
		logic [10:0]      freed;
		logic [10:0]      occupied;
	} pool_result_t;

	logic [31:0] slot_pay [SLOTS];
	logic [15:0] slot_gen [SLOTS];
	bit          slot_used [SLOTS];
	bit          slot_doomed [SLOTS];
	logic [9:0]  free_lifo [SLOTS];
	int          lifo_depth;
	int          high_mark;
	int          occupied_total;

	pool_result_t due_results [$];
	pool_result_t want;

	function automatic bit handle_live(logic [9:0] idx, logic [15:0] hgen);
		return idx < high_mark && slot_gen[idx] == hgen && slot_used[idx];
	endfunction

	function automatic pool_result_t predict_pool_op(ghp_pkg::op_t op, logic [9:0] idx,
			logic [15:0] hgen, logic [31:0] pay);
		pool_result_t r;
		logic [9:0]   s;
		bit           got;
		int           freed;
		r = '0;
		r.status = ghp_pkg::ST_OK;
		r.index = idx;
		case (op)
		ghp_pkg::OP_REGISTER: begin
			got = 1'b1;
			s = '0;
			if (lifo_depth > 0) begin
				lifo_depth--;
				s = free_lifo[lifo_depth];
			end else if (high_mark < SLOTS) begin
				s = 10'(high_mark);
				high_mark++;
			end else begin
				got = 1'b0;
			end
			if (got) begin
				slot_pay[s] = pay;
				if (!slot_used[s])
					occupied_total++;
				slot_used[s] = 1'b1;
				slot_doomed[s] = 1'b0;
				r.index = s;
				r.generation = slot_gen[s];
			end else begin
				r.status = ghp_pkg::ST_FULL;
				r.index = '0;
			end
		end
		ghp_pkg::OP_DESTROY: begin
			if (handle_live(idx, hgen))
				slot_doomed[idx] = 1'b1;
			else
				r.status = ghp_pkg::ST_INVALID;
		end
		ghp_pkg::OP_RESOLVE: begin
			if (handle_live(idx, hgen))
				r.payload = slot_pay[idx];
			else
				r.status = ghp_pkg::ST_INVALID;
		end
		ghp_pkg::OP_COLLECT: begin
			freed = 0;
			// ascending sweep, so the highest freed index ends on top of the stack
			for (int i = 0; i < high_mark; i++) begin
				if (slot_doomed[i] && slot_used[i]) begin
					slot_used[i] = 1'b0;
					slot_doomed[i] = 1'b0;
					slot_pay[i] = '0;
					slot_gen[i] = slot_gen[i] + 16'd1;
					if (lifo_depth < SLOTS) begin
						free_lifo[lifo_depth] = 10'(i);
						lifo_depth++;
					end
					if (occupied_total > 0)
						occupied_total--;
					freed++;
				end
			end
			r.freed = 11'(freed);
		end
		default: ;
		endcase
		r.occupied = 11'(occupied_total);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, exp_val);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_pay[i] = '0;
				slot_gen[i] = '0;
				slot_used[i] = 1'b0;
				slot_doomed[i] = 1'b0;
				free_lifo[i] = '0;
			end
			lifo_depth = 0;
			high_mark = 0;
			occupied_total = 0;
			due_results.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			// take the result beat first: it can never belong to a request of this edge
			if (rsp.valid && rsp.ready) begin
				if (due_results.size() == 0) begin
					report_mismatch("result beat with nothing outstanding, index",
						32'(rsp.result_index), 32'd0);
				end else begin
					want = due_results.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", 32'(rsp.status), 32'(want.status));
					if (rsp.result_index !== want.index)
						report_mismatch("result_index", 32'(rsp.result_index),
							32'(want.index));
					if (rsp.result_generation !== want.generation)
						report_mismatch("result_generation", 32'(rsp.result_generation),
							32'(want.generation));
					if (rsp.result_payload !== want.payload)
						report_mismatch("result_payload", rsp.result_payload, want.payload);
					if (rsp.freed_count !== want.freed)
						report_mismatch("freed_count", 32'(rsp.freed_count),
							32'(want.freed));
					if (rsp.occupied_count !== want.occupied)
						report_mismatch("occupied_count", 32'(rsp.occupied_count),
							32'(want.occupied));
				end
			end
			if (req.valid && req.ready)
				due_results.insert(due_results.size(),
					predict_pool_op(req.operation, req.slot_index,
						req.handle_generation, req.payload));
			pending_count = due_results.size();
		end
	end

endmodule

/* sim/tb_generational_handle_pool.sv */
// Testbench top for the generational handle pool: clock, reset, request
// stimulus and receiver stalls; ghp_pool_checker does the prediction.
// Depends on ghp_pkg, ghp_req_if, ghp_rsp_if, the pool and ghp_pool_checker.
module tb_generational_handle_pool;

	localparam int SLOTS       = 1024;
	localparam int CYCLE_LIMIT = 250_000;
	localparam int SETTLE      = SLOTS + 16;

	typedef struct packed {
		logic [9:0]  idx;
		logic [15:0] gen;
	} handle_t;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_count;
	int   burst_left;
	int   full_seen;

	ghp_pkg::op_t op_log [$];
	handle_t      live_h [$];
	handle_t      doomed_h [$];
	handle_t      old_h [$];

	ghp_req_if req_if ();
	ghp_rsp_if rsp_if ();

	generational_handle_pool dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	ghp_pool_checker #(.SLOTS(SLOTS)) pool_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_if),
		.rsp           (rsp_if),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// learn issued handles from the response stream
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready && op_log.size() > 0) begin
			if (op_log.pop_front() == ghp_pkg::OP_REGISTER) begin
				if (rsp_if.status == ghp_pkg::ST_OK)
					live_h.insert(live_h.size(), handle_t'{idx: rsp_if.result_index,
						gen: rsp_if.result_generation});
				else if (rsp_if.status == ghp_pkg::ST_FULL)
					full_seen <= full_seen + 1;
			end
		end
		if (arst_n && req_if.valid && req_if.ready)
			op_log.insert(op_log.size(), req_if.operation);
	end

	initial begin
		int mode;
		int span;
		int tick;
		rsp_if.ready = 1'b0;
		tick = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(8, 80);
			repeat (span) begin
				@(negedge clk);
				tick++;
				case (mode)
				0: rsp_if.ready = 1'b1;
				1: rsp_if.ready = ($urandom_range(0, 3) != 0);
				2: rsp_if.ready = ($urandom_range(0, 5) == 0);
				default: rsp_if.ready = (tick % 9) < 3;
				endcase
			end
		end
	end

	initial begin
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_generational_handle_pool failed");
		$finish;
	end

	// open a gap between bursts where due, and end on a falling edge
	task automatic lead_in();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				req_if.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
	endtask

	task automatic drive(ghp_pkg::op_t op, logic [9:0] idx, logic [15:0] hgen,
			logic [31:0] pay);
		req_if.valid = 1'b1;
		req_if.operation = op;
		req_if.slot_index = idx;
		req_if.handle_generation = hgen;
		req_if.payload = pay;
		do @(posedge clk); while (!req_if.ready);
	endtask

	task automatic issue(ghp_pkg::op_t op, logic [9:0] idx, logic [15:0] hgen,
			logic [31:0] pay);
		lead_in();
		drive(op, idx, hgen, pay);
	endtask

	// hold the sender until every outstanding beat has come back
	task automatic drain();
		@(negedge clk);
		req_if.valid = 1'b0;
		while (pending_count != 0) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_payload();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return $urandom;
	endfunction

	// destroyed handles go stale once a sweep has been sent
	function automatic void retire_doomed();
		while (doomed_h.size() > 0)
			old_h.insert(old_h.size(), doomed_h.pop_front());
		while (old_h.size() > 64)
			void'(old_h.pop_front());
	endfunction

	function automatic handle_t pick_handle(bit retire);
		int      roll;
		int      k;
		handle_t h;
		roll = $urandom_range(0, 99);
		if (roll < 70 && live_h.size() > 0) begin
			k = $urandom_range(0, live_h.size() - 1);
			h = live_h[k];
			if (retire) begin
				live_h.delete(k);
				doomed_h.insert(doomed_h.size(), h);
			end
		end else if (roll < 82 && doomed_h.size() > 0) begin
			h = doomed_h[$urandom_range(0, doomed_h.size() - 1)];
		end else if (roll < 92 && old_h.size() > 0) begin
			h = old_h[$urandom_range(0, old_h.size() - 1)];
		end else begin
			h.idx = 10'($urandom);
			h.gen = 16'($urandom);
		end
		return h;
	endfunction

	task automatic step(int reg_pct, int sweep_pct);
		int      roll;
		handle_t h;
		lead_in();
		roll = $urandom_range(0, 99);
		if (roll < reg_pct) begin
			drive(ghp_pkg::OP_REGISTER, 10'($urandom), 16'($urandom), pick_payload());
		end else if (roll < reg_pct + sweep_pct) begin
			drive(ghp_pkg::OP_COLLECT, 10'($urandom), 16'($urandom), $urandom);
			retire_doomed();
		end else begin
			h = pick_handle(roll[0]);
			drive(roll[0] ? ghp_pkg::OP_DESTROY : ghp_pkg::OP_RESOLVE, h.idx, h.gen,
				$urandom);
		end
	endtask

	initial begin
		handle_t h;
		int      k;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.operation = ghp_pkg::OP_REGISTER;
		req_if.slot_index = '0;
		req_if.handle_generation = '0;
		req_if.payload = '0;
		burst_left = 0;
		full_seen = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty pool: everything is invalid, sweep frees nothing
		issue(ghp_pkg::OP_RESOLVE, 10'd0, 16'd0, 32'd0);
		issue(ghp_pkg::OP_DESTROY, 10'd1023, 16'hffff, 32'hffff_ffff);
		issue(ghp_pkg::OP_COLLECT, 10'd0, 16'd0, 32'd0);
		// zero payload is an ordinary value
		issue(ghp_pkg::OP_REGISTER, 10'd0, 16'd0, 32'd0);
		issue(ghp_pkg::OP_REGISTER, 10'd1023, 16'hffff, 32'hffff_ffff);
		issue(ghp_pkg::OP_REGISTER, 10'd0, 16'd0, 32'ha5a5_5a5a);
		issue(ghp_pkg::OP_RESOLVE, 10'd0, 16'd0, 32'd0);
		issue(ghp_pkg::OP_RESOLVE, 10'd1, 16'd0, 32'd0);
		issue(ghp_pkg::OP_RESOLVE, 10'd1, 16'd1, 32'd0);
		issue(ghp_pkg::OP_RESOLVE, 10'd3, 16'd0, 32'd0);
		// repeated destroy stays pending and still resolves until the sweep
		issue(ghp_pkg::OP_DESTROY, 10'd1, 16'd0, 32'd0);
		issue(ghp_pkg::OP_DESTROY, 10'd1, 16'd0, 32'd0);
		issue(ghp_pkg::OP_RESOLVE, 10'd1, 16'd0, 32'd0);
		issue(ghp_pkg::OP_COLLECT, 10'd0, 16'd0, 32'd0);
		issue(ghp_pkg::OP_RESOLVE, 10'd1, 16'd0, 32'd0);
		issue(ghp_pkg::OP_DESTROY, 10'd1, 16'd1, 32'd0);
		issue(ghp_pkg::OP_REGISTER, 10'd0, 16'd0, 32'd1234);
		issue(ghp_pkg::OP_RESOLVE, 10'd1, 16'd1, 32'd0);
		// two freed in one sweep come back last-in first-out
		issue(ghp_pkg::OP_DESTROY, 10'd0, 16'd0, 32'd0);
		issue(ghp_pkg::OP_DESTROY, 10'd2, 16'd0, 32'd0);
		issue(ghp_pkg::OP_COLLECT, 10'd0, 16'd0, 32'd0);
		issue(ghp_pkg::OP_REGISTER, 10'd0, 16'd0, 32'h0000_0001);
		issue(ghp_pkg::OP_REGISTER, 10'd0, 16'd0, 32'h8000_0000);
		issue(ghp_pkg::OP_REGISTER, 10'd0, 16'd0, 32'h7fff_ffff);
		drain();
		old_h = live_h;
		live_h.delete();

		repeat (30) step(45, 3);

		// fill the pool until registers come back full
		while (full_seen < 3) step(100, 0);
		drain();

		repeat (30) begin
			lead_in();
			if (live_h.size() > 0) begin
				k = $urandom_range(0, live_h.size() - 1);
				h = live_h[k];
				live_h.delete(k);
				doomed_h.insert(doomed_h.size(), h);
			end else begin
				h = pick_handle(1'b0);
			end
			drive(ghp_pkg::OP_DESTROY, h.idx, h.gen, $urandom);
		end
		issue(ghp_pkg::OP_COLLECT, 10'd0, 16'd0, 32'd0);
		retire_doomed();

		repeat (15) step(100, 0);
		repeat (30) step(40, 4);

		drain();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("tb_generational_handle_pool passed");
		else
			$display("tb_generational_handle_pool failed");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/ghp_pkg.sv
hw/rtl/ghp_req_if.sv
hw/rtl/ghp_rsp_if.sv
hw/rtl/generational_handle_pool.sv
sim/ghp_pool_checker.sv
sim/tb_generational_handle_pool.sv
